// ===== src/ppru_pkg.sv =====
// Shared types and constants of the packed pixel row unpacker.
`default_nettype none

package ppru_pkg;

  // Default dimension limits handed to the top level parameters.
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Width of the dimension registers and the largest value they can hold.
  localparam int DIM_W   = 13;
  localparam int DIM_MAX = (1 << DIM_W) - 1;

  // Width of the reported pixel coordinates.
  localparam int COORD_W = 12;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_CODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_ROWS    = 2'd3;

  // Depth codes.
  localparam logic [1:0] DEPTH_1BPP = 2'd0;
  localparam logic [1:0] DEPTH_2BPP = 2'd1;
  localparam logic [1:0] DEPTH_4BPP = 2'd2;
  localparam logic [1:0] DEPTH_8BPP = 2'd3;

  // Register reset values.
  localparam logic [1:0]       RST_DEPTH_CODE   = DEPTH_8BPP;
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd1;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd1;
  localparam logic             RST_FLIP_ROWS    = 1'b1;

  // Entries of the queue between the byte classifier and the pixel emitter.
  localparam int QUEUE_DEPTH = 4;

  // Current configuration as seen by the byte classifier.
  typedef struct packed {
    logic [1:0]       depth_code;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             flip_rows;
  } cfg_t;

  // One classified byte: everything the emitter needs to produce its pixels.
  typedef struct packed {
    logic [7:0]         data_byte;
    logic [1:0]         depth_code;
    logic [3:0]         count;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y;
    logic               ends_frame;
  } item_t;

endpackage

`default_nettype wire

// ===== src/packed_pixel_row_unpacker_unit.sv =====
// Top level of the packed pixel row unpacker: configuration registers and the two halves.
`default_nettype none

// Unpacks indexed bitmap pixel data (1, 2, 4 or 8 bits per pixel) given one byte per word
// and returns one pixel per word with its column and row. A byte word is taken in the
// cycle it is pushed whenever the four-entry byte queue has room; padding bytes and bytes
// after the frame are taken and dropped. Pixels leave at one per cycle while the output is
// free or popped, from a single emitter; a byte yields up to 8 / bits-per-pixel pixels
// (8 at 1 bpp, 1 at 8 bpp) via a queue entry, the working byte and the output register.
// Configuration must be written only while no pixel is pending; it is not enforced.
module packed_pixel_row_unpacker_unit #(
  parameter int MAX_WIDTH  = ppru_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ppru_pkg::DEF_MAX_HEIGHT
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_push,
  output logic                                in_full,
  input  wire  [7:0]                          in_data_byte,
  input  wire                                 out_pop,
  output logic                                out_empty,
  output logic [7:0]                          out_pixel_value,
  output logic [ppru_pkg::COORD_W-1:0]        out_pixel_x,
  output logic [ppru_pkg::COORD_W-1:0]        out_pixel_y,
  output logic                                out_last_of_item,
  output logic                                out_last_of_frame,
  input  wire                                 cfg_we,
  input  wire  [ppru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [ppru_pkg::CFG_DATA_W-1:0]     cfg_data
);

  ppru_pkg::cfg_t  cfg_r;
  ppru_pkg::item_t q_in_item;
  ppru_pkg::item_t q_head;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_not_empty;
  logic            in_accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_code   <= ppru_pkg::RST_DEPTH_CODE;
      cfg_r.image_width  <= ppru_pkg::RST_IMAGE_WIDTH;
      cfg_r.image_height <= ppru_pkg::RST_IMAGE_HEIGHT;
      cfg_r.flip_rows    <= ppru_pkg::RST_FLIP_ROWS;
    end else if (cfg_we) begin
      case (cfg_index)
        ppru_pkg::REG_DEPTH_CODE:   cfg_r.depth_code   <= cfg_data[1:0];
        ppru_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data[ppru_pkg::DIM_W-1:0];
        ppru_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[ppru_pkg::DIM_W-1:0];
        ppru_pkg::REG_FLIP_ROWS:    cfg_r.flip_rows    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input handshake: a word is taken whenever the byte queue has room.
  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  ppru_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_data_byte),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in_item)
  );

  ppru_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head_item (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  ppru_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_head            (q_head),
    .q_not_empty       (q_not_empty),
    .q_pop             (q_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_pixel_value   (out_pixel_value),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_last_of_item  (out_last_of_item),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

`default_nettype wire

// ===== src/ppru_front.sv =====
// Byte classifier: tracks the position in the frame and queues pixel-bearing bytes.
`default_nettype none

module ppru_front #(
  parameter int MAX_WIDTH  = ppru_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ppru_pkg::DEF_MAX_HEIGHT
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 accept,
  input  wire  [7:0]          data_byte,
  input  ppru_pkg::cfg_t      cfg,
  input  wire                 q_full,
  output logic                q_push,
  output ppru_pkg::item_t     q_item
);

  // Effective dimension limits and the counter widths that follow from them.
  localparam int WMAX   = (MAX_WIDTH < ppru_pkg::DIM_MAX) ? MAX_WIDTH : ppru_pkg::DIM_MAX;
  localparam int HMAX   = (MAX_HEIGHT < ppru_pkg::DIM_MAX) ? MAX_HEIGHT : ppru_pkg::DIM_MAX;
  localparam int COL_W  = $clog2(WMAX + 1);
  localparam int ROW_W  = $clog2(HMAX + 1);
  localparam int RB_MAX = ((WMAX * 8 + 31) / 32) * 4;
  localparam int RB_W   = $clog2(RB_MAX + 1);
  localparam int BIR_W  = $clog2(RB_MAX);

  logic [BIR_W-1:0] bir_r, bir_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             fc_r, fc_nxt;

  logic [COL_W-1:0] w_c;
  logic [ROW_W-1:0] h_c;
  logic [3:0]       per_byte;
  logic [COL_W-1:0] rem;
  logic [3:0]       n;
  logic [31:0]      rb_calc;
  logic [RB_W-1:0]  row_bytes;
  logic [RB_W-1:0]  bir_inc;
  logic [ROW_W-1:0] row_inc;
  logic [ROW_W-1:0] y_val;
  logic [31:0]      y32;
  logic [31:0]      x32;

  // Width and height with zero taken as one and large values saturated.
  always_comb begin
    if (cfg.image_width == '0) begin
      w_c = COL_W'(1);
    end else if (cfg.image_width > ppru_pkg::DIM_W'(WMAX)) begin
      w_c = COL_W'(WMAX);
    end else begin
      w_c = COL_W'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h_c = ROW_W'(1);
    end else if (cfg.image_height > ppru_pkg::DIM_W'(HMAX)) begin
      h_c = ROW_W'(HMAX);
    end else begin
      h_c = ROW_W'(cfg.image_height);
    end
  end

  // Pixels in this byte: the depth limit or what is left of the row.
  assign per_byte = 4'd8 >> cfg.depth_code;
  assign rem      = w_c - col_r;
  always_comb begin
    if (col_r >= w_c) begin
      n = 4'd0;
    end else if (rem < COL_W'(per_byte)) begin
      n = rem[3:0];
    end else begin
      n = per_byte;
    end
  end

  // Padded row length in bytes: whole 32-bit words.
  assign rb_calc   = (((32'(w_c) << cfg.depth_code) + 32'd31) >> 5) << 2;
  assign row_bytes = rb_calc[RB_W-1:0];
  assign bir_inc   = RB_W'(bir_r) + RB_W'(1);
  assign row_inc   = row_r + ROW_W'(1);

  // Output row after the optional flip, and coordinates cut to twelve bits.
  assign y_val = cfg.flip_rows ? (h_c - ROW_W'(1) - row_r) : row_r;
  assign y32   = 32'(y_val);
  assign x32   = 32'(col_r);

  always_comb begin
    q_item.data_byte  = data_byte;
    q_item.depth_code = cfg.depth_code;
    q_item.count      = n;
    q_item.x_start    = x32[ppru_pkg::COORD_W-1:0];
    q_item.y          = y32[ppru_pkg::COORD_W-1:0];
    q_item.ends_frame = (row_r == h_c - ROW_W'(1)) && (rem <= COL_W'(per_byte));
  end

  // Position update for each accepted word.
  always_comb begin
    bir_nxt = bir_r;
    col_nxt = col_r;
    row_nxt = row_r;
    fc_nxt  = fc_r;
    q_push  = 1'b0;
    if (accept && !fc_r) begin
      if (row_r >= h_c) begin
        fc_nxt = 1'b1;
      end else begin
        q_push  = (n != 4'd0);
        col_nxt = col_r + COL_W'(n);
        if (bir_inc >= row_bytes) begin
          bir_nxt = '0;
          col_nxt = '0;
          row_nxt = row_inc;
          if (row_inc >= h_c) begin
            fc_nxt = 1'b1;
          end
        end else begin
          bir_nxt = BIR_W'(bir_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bir_r <= '0;
      col_r <= '0;
      row_r <= '0;
      fc_r  <= 1'b0;
    end else begin
      bir_r <= bir_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      fc_r  <= fc_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A finished frame stays finished until reset.
  a_fc_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r |=> fc_r) else $error("frame complete flag cleared without reset");

  // The classifier never pushes into a full queue.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into full queue");

  // Words after the frame leave the position untouched.
  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && fc_r) |=> ($stable(row_r) && $stable(col_r) && $stable(bir_r)))
    else $error("word after frame changed the position");
`endif

endmodule

`default_nettype wire

// ===== src/ppru_queue.sv =====
// Short queue of classified bytes between the classifier and the emitter.
`default_nettype none

module ppru_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  ppru_pkg::item_t  push_item,
  input  wire              pop,
  output ppru_pkg::item_t  head_item,
  output logic             not_empty,
  output logic             full
);

  localparam int DEPTH = ppru_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ppru_pkg::item_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_item = mem_r[rd_ptr_r];

  // Pointer and fill count update, wrapping at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/ppru_back.sv =====
// Pixel emitter: walks a queued byte a pixel per cycle into a free output register.
`default_nettype none

module ppru_back (
  input  wire                           clk,
  input  wire                           rst_n,
  input  ppru_pkg::item_t               q_head,
  input  wire                           q_not_empty,
  output logic                          q_pop,
  input  wire                           out_pop,
  output logic                          out_empty,
  output logic [7:0]                    out_pixel_value,
  output logic [ppru_pkg::COORD_W-1:0]  out_pixel_x,
  output logic [ppru_pkg::COORD_W-1:0]  out_pixel_y,
  output logic                          out_last_of_item,
  output logic                          out_last_of_frame
);

  // Byte being worked on.
  logic                          cur_valid_r, cur_valid_nxt;
  logic [7:0]                    cur_byte_r, cur_byte_nxt;
  logic [1:0]                    cur_dc_r, cur_dc_nxt;
  logic [3:0]                    cur_cnt_r, cur_cnt_nxt;
  logic [ppru_pkg::COORD_W-1:0]  cur_x_r, cur_x_nxt;
  logic [ppru_pkg::COORD_W-1:0]  cur_y_r, cur_y_nxt;
  logic                          cur_ef_r, cur_ef_nxt;

  // Output register.
  logic                          out_valid_r;
  logic [7:0]                    pix_r;
  logic [ppru_pkg::COORD_W-1:0]  px_r;
  logic [ppru_pkg::COORD_W-1:0]  py_r;
  logic                          loi_r;
  logic                          lof_r;

  logic       emit;
  logic       last;
  logic [7:0] pix_val;
  logic [3:0] shamt;

  assign emit  = cur_valid_r && (!out_valid_r || out_pop);
  assign last  = (cur_cnt_r == 4'd1);
  assign q_pop = q_not_empty && (!cur_valid_r || (emit && last));
  assign shamt = 4'd1 << cur_dc_r;

  // The top bits of the working byte form the next pixel.
  always_comb begin
    case (cur_dc_r)
      ppru_pkg::DEPTH_1BPP: pix_val = {7'd0, cur_byte_r[7]};
      ppru_pkg::DEPTH_2BPP: pix_val = {6'd0, cur_byte_r[7:6]};
      ppru_pkg::DEPTH_4BPP: pix_val = {4'd0, cur_byte_r[7:4]};
      default:              pix_val = cur_byte_r;
    endcase
  end

  // Load a new byte when the current one is done, else step to the next pixel.
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_byte_nxt  = cur_byte_r;
    cur_dc_nxt    = cur_dc_r;
    cur_cnt_nxt   = cur_cnt_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    cur_ef_nxt    = cur_ef_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      cur_byte_nxt  = q_head.data_byte;
      cur_dc_nxt    = q_head.depth_code;
      cur_cnt_nxt   = q_head.count;
      cur_x_nxt     = q_head.x_start;
      cur_y_nxt     = q_head.y;
      cur_ef_nxt    = q_head.ends_frame;
    end else if (emit) begin
      cur_valid_nxt = !last;
      cur_byte_nxt  = cur_byte_r << shamt;
      cur_cnt_nxt   = cur_cnt_r - 4'd1;
      cur_x_nxt     = cur_x_r + ppru_pkg::COORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
    end
    cur_byte_r <= cur_byte_nxt;
    cur_dc_r   <= cur_dc_nxt;
    cur_cnt_r  <= cur_cnt_nxt;
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    cur_ef_r   <= cur_ef_nxt;
  end

  // Output register: refilled on every emitted pixel, emptied when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
    if (emit) begin
      pix_r <= pix_val;
      px_r  <= cur_x_r;
      py_r  <= cur_y_r;
      loi_r <= last;
      lof_r <= last && cur_ef_r;
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_pixel_value   = pix_r;
  assign out_pixel_x       = px_r;
  assign out_pixel_y       = py_r;
  assign out_last_of_item  = loi_r;
  assign out_last_of_frame = lof_r;

`ifndef NO_ASSERTIONS
  // A byte in work always has between one and eight pixels left.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_cnt_r != 4'd0 && cur_cnt_r <= 4'd8))
    else $error("pixel count of working byte out of range");

  // The frame's last pixel is always the last pixel of its byte.
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && lof_r) |-> loi_r)
    else $error("end of frame not at end of byte");

  // A held pixel is not overwritten while it waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |-> !emit)
    else $error("pixel emitted over a waiting one");
`endif

endmodule

`default_nettype wire
